// ----- src/ring_modulator_recursive_oscillator_defines.svh -----
// Assertion helpers used by the checker of the ring modulator.
`ifndef RING_MODULATOR_RECURSIVE_OSCILLATOR_DEFINES_SVH
`define RING_MODULATOR_RECURSIVE_OSCILLATOR_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define RMRO_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmro check failed");

// Next-cycle implication, off while reset is high.
`define RMRO_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmro check failed");

`endif

// ----- src/rmro_pkg.sv -----
package rmro_pkg;

  // Oscillator state width
  localparam int OSC_W = 16;
  // Shared multiplier operand and product widths
  localparam int A_W   = OSC_W + 6;
  localparam int B_W   = 9;
  localparam int P_W   = A_W + B_W;
  localparam int SUM_W = P_W + 1;
  localparam int CAR_W = 16;

  // Truncating shifts: oscillator factors are over 16, mixing over 256
  localparam int SHIFT_OSC = 4;
  localparam int SHIFT_MIX = 8;

  // Register map
  localparam int CFG_W   = 8;
  localparam int AMP_W   = 7;
  localparam int IDX_W   = 2;
  localparam logic [IDX_W-1:0] REG_AMP    = 2'd0;
  localparam logic [IDX_W-1:0] REG_FA     = 2'd1;
  localparam logic [IDX_W-1:0] REG_FB     = 2'd2;
  localparam logic [IDX_W-1:0] REG_PERIOD = 2'd3;

  // Register reset values
  localparam logic [AMP_W-1:0] AMP_RST    = 7'd126;
  localparam logic [CFG_W-1:0] FA_RST     = 8'd11;
  localparam logic [CFG_W-1:0] FB_RST     = 8'd23;
  localparam logic [CFG_W-1:0] PERIOD_RST = 8'd41;

  // Offset-binary shift of the mixed byte
  localparam logic [7:0] MIX_OFFSET = 8'd128;

  // Saturation bounds of the oscillator, at the update sum width
  localparam logic signed [SUM_W-1:0] OSC_MAX =
    {{(SUM_W-OSC_W+1){1'b0}}, {(OSC_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] OSC_MIN = ~OSC_MAX;

  // One request to the shared multiply / truncating-shift unit
  typedef struct packed {
    logic signed [A_W-1:0] a;
    logic signed [B_W-1:0] b;
    logic                  mix;
  } mul_op_t;

  // Clamp an update sum to the oscillator range
  function automatic logic signed [OSC_W-1:0] sat_osc(input logic signed [SUM_W-1:0] v);
    logic signed [OSC_W-1:0] r;
    if (v > OSC_MAX) begin
      r = OSC_MAX[OSC_W-1:0];
    end else if (v < OSC_MIN) begin
      r = OSC_MIN[OSC_W-1:0];
    end else begin
      r = v[OSC_W-1:0];
    end
    return r;
  endfunction

  // Clamp the oscillator value to the 16-bit carrier output
  function automatic logic signed [CAR_W-1:0] sat_carrier(input logic signed [OSC_W-1:0] v);
    logic signed [32:0]      w;
    logic signed [CAR_W-1:0] r;
    w = 33'(v);
    if (w > 33'sd32767) begin
      r = 16'sh7fff;
    end else if (w < -33'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = w[CAR_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/rmro_mul.sv -----
// Shared signed multiplier followed by a divide by 16 or 256 that
// truncates toward zero. Result is registered.
module rmro_mul (
  input  logic                             clk,
  input  rmro_pkg::mul_op_t                op,
  output logic signed [rmro_pkg::P_W-1:0]  prod_q
);

  localparam logic signed [rmro_pkg::P_W-1:0] BIAS_OSC =
    rmro_pkg::P_W'((1 << rmro_pkg::SHIFT_OSC) - 1);
  localparam logic signed [rmro_pkg::P_W-1:0] BIAS_MIX =
    rmro_pkg::P_W'((1 << rmro_pkg::SHIFT_MIX) - 1);

  logic signed [rmro_pkg::P_W-1:0] prod;
  logic signed [rmro_pkg::P_W-1:0] bias;
  logic signed [rmro_pkg::P_W-1:0] biased;
  logic signed [rmro_pkg::P_W-1:0] quot;

  // Negative products get a bias so the arithmetic shift rounds toward zero
  always_comb begin
    prod   = rmro_pkg::P_W'(op.a) * rmro_pkg::P_W'(op.b);
    bias   = '0;
    if (prod[rmro_pkg::P_W-1]) begin
      bias = op.mix ? BIAS_MIX : BIAS_OSC;
    end
    biased = prod + bias;
    quot   = op.mix ? (biased >>> rmro_pkg::SHIFT_MIX) : (biased >>> rmro_pkg::SHIFT_OSC);
  end

  always_ff @(posedge clk) begin
    prod_q <= quot;
  end

endmodule

// ----- src/ring_modulator_recursive_oscillator.sv -----
// Sequence: an accepted sample walks MUL1, MUL2, UPD, MIX and OUT, or only MIX and OUT
// when the period wraps; no new sample is taken until it leaves OUT. A single shared
// multiplier does both oscillator factor products and the mixing product.
// The output register frees the input side while a result waits.
// Reset (synchronous, active high): registers to 126/11/23/41, sine 0,
// cosine 126, phase 0, no result pending.
module ring_modulator_recursive_oscillator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [rmro_pkg::IDX_W-1:0]           cfg_index,
  input  logic [rmro_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [7:0]                    audio_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           mixed_sample,
  output logic signed [rmro_pkg::CAR_W-1:0]    carrier_value
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL1 = 6'b000010,
    ST_MUL2 = 6'b000100,
    ST_UPD  = 6'b001000,
    ST_MIX  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [rmro_pkg::AMP_W-1:0]         amp;
  logic [rmro_pkg::CFG_W-1:0]         fa;
  logic [rmro_pkg::CFG_W-1:0]         fb;
  logic [rmro_pkg::CFG_W-1:0]         period;
  logic signed [rmro_pkg::OSC_W-1:0]  s1;
  logic signed [rmro_pkg::OSC_W-1:0]  s2;
  logic [7:0]                         phase;
  logic signed [7:0]                  sample;

  logic                               accept;
  logic                               out_load;
  logic [7:0]                         phase_inc;
  logic                               wrap;
  logic [rmro_pkg::AMP_W-1:0]         amp_reload;
  rmro_pkg::mul_op_t                  op;
  logic signed [rmro_pkg::P_W-1:0]    prod_q;

  // A register write takes the cycle; no item is taken alongside it
  assign in_ready  = (state == ST_IDLE) && !cfg_we;
  assign accept    = in_valid && in_ready;
  assign out_load  = (state == ST_OUT) && (!out_valid || out_ready);
  assign phase_inc = phase + 8'd1;
  assign wrap      = (phase_inc >= period);
  assign amp_reload = (cfg_we && cfg_index == rmro_pkg::REG_AMP) ?
                      cfg_data[rmro_pkg::AMP_W-1:0] : amp;

  // Operand select for the shared unit; mixing operands also cover the stall
  always_comb begin
    op.a   = rmro_pkg::A_W'(s2);
    op.b   = rmro_pkg::B_W'(sample);
    op.mix = 1'b1;
    case (state)
      ST_MUL1: begin
        op.a   = rmro_pkg::A_W'(s1) + rmro_pkg::A_W'(s2);
        op.b   = $signed({1'b0, fa});
        op.mix = 1'b0;
      end
      ST_MUL2: begin
        op.a   = $signed(prod_q[rmro_pkg::A_W-1:0]);
        op.b   = $signed({1'b0, fb});
        op.mix = 1'b0;
      end
      default: begin
        op.mix = 1'b1;
      end
    endcase
  end

  rmro_mul u_mul (
    .clk    (clk),
    .op     (op),
    .prod_q (prod_q)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && !cfg_we) begin
          state_next = wrap ? ST_MIX : ST_MUL1;
        end
      end
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_UPD;
      ST_UPD:  state_next = ST_MIX;
      ST_MIX:  state_next = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers and oscillator state
  always_ff @(posedge clk) begin
    if (rst) begin
      amp    <= rmro_pkg::AMP_RST;
      fa     <= rmro_pkg::FA_RST;
      fb     <= rmro_pkg::FB_RST;
      period <= rmro_pkg::PERIOD_RST;
      s1     <= '0;
      s2     <= $signed({{(rmro_pkg::OSC_W-rmro_pkg::AMP_W){1'b0}}, rmro_pkg::AMP_RST});
      phase  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rmro_pkg::REG_AMP:    amp    <= cfg_data[rmro_pkg::AMP_W-1:0];
        rmro_pkg::REG_FA:     fa     <= cfg_data;
        rmro_pkg::REG_FB:     fb     <= cfg_data;
        rmro_pkg::REG_PERIOD: period <= cfg_data;
        default: ;
      endcase
      s1    <= '0;
      s2    <= $signed({{(rmro_pkg::OSC_W-rmro_pkg::AMP_W){1'b0}}, amp_reload});
      phase <= '0;
    end else if (accept) begin
      if (wrap) begin
        s1    <= '0;
        s2    <= $signed({{(rmro_pkg::OSC_W-rmro_pkg::AMP_W){1'b0}}, amp});
        phase <= '0;
      end else begin
        phase <= phase_inc;
      end
    end else if (state == ST_UPD) begin
      // prod_q holds c here
      s1 <= rmro_pkg::sat_osc(rmro_pkg::SUM_W'(prod_q) + rmro_pkg::SUM_W'(s2));
      s2 <= rmro_pkg::sat_osc(rmro_pkg::SUM_W'(prod_q) - rmro_pkg::SUM_W'(s1));
    end
  end

  // Captured sample
  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= audio_sample;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mixed_sample  <= prod_q[7:0] + rmro_pkg::MIX_OFFSET;
      carrier_value <= rmro_pkg::sat_carrier(s2);
    end
  end

endmodule

// ----- src/rmro_chk.sv -----
`include "ring_modulator_recursive_oscillator_defines.svh"

// Port-level checks for the ring modulator
module rmro_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [7:0]                         mixed_sample,
  input logic signed [rmro_pkg::CAR_W-1:0]  carrier_value
);

  // A stalled result holds its value
  `RMRO_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(mixed_sample) && $stable(carrier_value))

  // One item at a time: busy right after an accept
  `RMRO_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // A zero carrier mixes to the offset-binary midpoint
  `RMRO_ASSERT_IMP(a_zero_carrier_mid, clk, rst, out_valid && carrier_value == '0, mixed_sample == rmro_pkg::MIX_OFFSET)

endmodule

bind ring_modulator_recursive_oscillator rmro_chk u_rmro_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .mixed_sample  (mixed_sample),
  .carrier_value (carrier_value)
);
